FILE: src/cbt_pkg.sv
// Shared types and constants for the CSV byte tokenizer.
// Used by every module of the block; has no dependencies of its own.
package cbt_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned QueueD   = 2;
  localparam int unsigned QueuePtrW = 1;
  localparam int unsigned QueueCntW = 2;

  localparam logic [ByteW-1:0] ChDquote = 8'h22;
  localparam logic [ByteW-1:0] ChSquote = 8'h27;
  localparam logic [ByteW-1:0] ChLf     = 8'h0A;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;

  localparam logic [ByteW-1:0] DelimReset = 8'd44;

  localparam logic [CfgIdxW-1:0] CfgDelimiter  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSkipHeader = 1'b1;

  typedef enum logic [4:0] {
    ModeLineStart  = 5'b00001,
    ModeFieldStart = 5'b00010,
    ModeUnquoted   = 5'b00100,
    ModeQuoted     = 5'b01000,
    ModeQuoteSeen  = 5'b10000
  } mode_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             eos;
    logic             is_dquote;
    logic             is_squote;
    logic             is_delim;
    logic             is_crlf;
  } class_t;

endpackage

FILE: src/csv_byte_tokenizer_top.sv
// Top level of the CSV byte tokenizer: configuration registers, front, queue and back.
// Depends on cbt_pkg, cbt_front, cbt_queue and cbt_back.
//
// The input stream carries one text byte per beat in s_axis_tdata, and
// s_axis_tuser set marks end of stream, which closes any open record.
// The output stream carries at most one field content byte per beat, with
// the byte-valid and field-end flags in tuser and the record end on tlast.
// Bytes that give no result, such as quotes, skipped empty lines and the
// whole first record when header skipping is on, produce no output beat.
// The configuration channel writes the delimiter (index 0) or the
// header-skip flag (index 1) and is always ready; write it only while idle.
// An accepted input beat is written into the queue; the back part pops it
// from there and registers its output beat in the output register.
// The back part's parse state machine takes one byte per cycle, so the block
// sustains one input beat per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its beat and the
// two-entry queue absorbs input until it is full, then tready drops.
// Reset returns the parser to line start, clears the queue and output,
// sets the delimiter to a comma and turns header skipping off.
module csv_byte_tokenizer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [cbt_pkg::ByteW-1:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic                        s_axis_tuser,   // [0] end_of_stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [cbt_pkg::ByteW-1:0]   m_axis_tdata,   // [7:0] content_byte
  output logic [1:0]                  m_axis_tuser,   // [0] byte_valid, [1] field_end
  output logic                        m_axis_tlast,   // record_end
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cbt_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [cbt_pkg::ByteW-1:0]   cfg_data_i
);

  logic [cbt_pkg::ByteW-1:0] delimiter_q;
  logic                      skip_header_q;
  cbt_pkg::class_t           front_class, head_class;
  logic                      queue_full, queue_valid, queue_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delimiter_q   <= cbt_pkg::DelimReset;
      skip_header_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cbt_pkg::CfgDelimiter:  delimiter_q   <= cfg_data_i;
        cbt_pkg::CfgSkipHeader: skip_header_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  cbt_front u_front (
    .data_i      (s_axis_tdata),
    .eos_i       (s_axis_tuser),
    .delimiter_i (delimiter_q),
    .class_o     (front_class)
  );

  assign s_axis_tready = !queue_full;

  cbt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_data_i (front_class),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .head_o      (head_class)
  );

  cbt_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .skip_header_i    (skip_header_q),
    .in_valid_i       (queue_valid),
    .in_class_i       (head_class),
    .in_pop_o         (queue_pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_byte_o       (m_axis_tdata),
    .out_byte_valid_o (m_axis_tuser[0]),
    .out_field_end_o  (m_axis_tuser[1]),
    .out_record_end_o (m_axis_tlast)
  );

endmodule

FILE: src/cbt_front.sv
// Front part of the tokenizer: tags each input byte with its class.
// Depends on cbt_pkg.
module cbt_front (
  input  logic [cbt_pkg::ByteW-1:0] data_i,
  input  logic                      eos_i,
  input  logic [cbt_pkg::ByteW-1:0] delimiter_i,
  output cbt_pkg::class_t           class_o
);

  always_comb begin
    class_o.data      = data_i;
    class_o.eos       = eos_i;
    class_o.is_dquote = (data_i == cbt_pkg::ChDquote);
    class_o.is_squote = (data_i == cbt_pkg::ChSquote);
    class_o.is_delim  = (data_i == delimiter_i);
    class_o.is_crlf   = (data_i == cbt_pkg::ChCr) || (data_i == cbt_pkg::ChLf);
  end

endmodule

FILE: src/cbt_queue.sv
// Short queue of classified bytes between the front and back parts.
// Depends on cbt_pkg.
module cbt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cbt_pkg::class_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output cbt_pkg::class_t head_o
);

  cbt_pkg::class_t                    mem_q [cbt_pkg::QueueD];
  logic [cbt_pkg::QueuePtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [cbt_pkg::QueuePtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [cbt_pkg::QueueCntW-1:0]      count_q, count_d;
  logic                               do_push, do_pop;

  assign full_o  = (count_q == cbt_pkg::QueueCntW'(cbt_pkg::QueueD));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: src/cbt_back.sv
// Back part of the tokenizer: parse state machine and output register.
// Depends on cbt_pkg.
module cbt_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      skip_header_i,
  input  logic                      in_valid_i,
  input  cbt_pkg::class_t           in_class_i,
  output logic                      in_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [cbt_pkg::ByteW-1:0] out_byte_o,
  output logic                      out_byte_valid_o,
  output logic                      out_field_end_o,
  output logic                      out_record_end_o
);

  cbt_pkg::mode_e            mode_q, mode_d;
  logic                      qsingle_q, qsingle_d;
  logic                      header_done_q, header_done_d;
  logic                      out_valid_q, out_valid_d;
  logic [cbt_pkg::ByteW-1:0] byte_q;
  logic                      bvalid_q, fend_q, rend_q;
  logic                      vld, fend, rend, quote_match, emit;

  assign in_pop_o    = in_valid_i && (!out_valid_q || out_ready_i);
  assign quote_match = qsingle_q ? in_class_i.is_squote : in_class_i.is_dquote;

  always_comb begin
    mode_d    = mode_q;
    qsingle_d = qsingle_q;
    vld       = 1'b0;
    fend      = 1'b0;
    rend      = 1'b0;
    if (in_class_i.eos) begin
      if (mode_q != cbt_pkg::ModeLineStart) begin
        fend = 1'b1;
        rend = 1'b1;
      end
      mode_d = cbt_pkg::ModeLineStart;
    end else begin
      unique case (mode_q)
        cbt_pkg::ModeUnquoted: begin
          priority if (in_class_i.is_delim) begin
            fend   = 1'b1;
            mode_d = cbt_pkg::ModeFieldStart;
          end else if (in_class_i.is_crlf) begin
            fend   = 1'b1;
            rend   = 1'b1;
            mode_d = cbt_pkg::ModeLineStart;
          end else begin
            vld = 1'b1;
          end
        end
        cbt_pkg::ModeQuoted: begin
          if (quote_match) begin
            mode_d = cbt_pkg::ModeQuoteSeen;
          end else begin
            vld = 1'b1;
          end
        end
        cbt_pkg::ModeQuoteSeen: begin
          priority if (quote_match) begin
            vld    = 1'b1;
            mode_d = cbt_pkg::ModeQuoted;
          end else if (in_class_i.is_delim) begin
            fend   = 1'b1;
            mode_d = cbt_pkg::ModeFieldStart;
          end else begin
            fend   = 1'b1;
            rend   = 1'b1;
            mode_d = cbt_pkg::ModeLineStart;
          end
        end
        default: begin
          priority if (mode_q != cbt_pkg::ModeFieldStart && in_class_i.is_crlf) begin
            mode_d = cbt_pkg::ModeLineStart;
          end else if (in_class_i.is_dquote || in_class_i.is_squote) begin
            qsingle_d = in_class_i.is_squote;
            mode_d    = cbt_pkg::ModeQuoted;
          end else if (in_class_i.is_delim) begin
            fend   = 1'b1;
            mode_d = cbt_pkg::ModeFieldStart;
          end else if (in_class_i.is_crlf) begin
            fend   = 1'b1;
            rend   = 1'b1;
            mode_d = cbt_pkg::ModeLineStart;
          end else begin
            vld    = 1'b1;
            mode_d = cbt_pkg::ModeUnquoted;
          end
        end
      endcase
    end
  end

  always_comb begin
    emit          = (vld || fend) && !(skip_header_i && !header_done_q);
    header_done_d = header_done_q || rend;
    out_valid_d   = out_valid_q && !out_ready_i;
    if (in_pop_o) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= cbt_pkg::ModeLineStart;
      qsingle_q     <= 1'b0;
      header_done_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_pop_o) begin
        mode_q        <= mode_d;
        qsingle_q     <= qsingle_d;
        header_done_q <= header_done_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_pop_o && emit) begin
      byte_q   <= vld ? in_class_i.data : '0;
      bvalid_q <= vld;
      fend_q   <= fend;
      rend_q   <= rend;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = byte_q;
  assign out_byte_valid_o = bvalid_q;
  assign out_field_end_o  = fend_q;
  assign out_record_end_o = rend_q;

endmodule

FILE: src/cbt_checker.sv
// Port-level checker for the CSV byte tokenizer and its bind to the top level.
// Depends on cbt_pkg and csv_byte_tokenizer_top.
module cbt_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [cbt_pkg::ByteW-1:0] m_axis_tdata,
  input logic [1:0]                m_axis_tuser,
  input logic                      m_axis_tlast
);

  // A record end always closes a field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tlast || m_axis_tuser[1]))
    else $error("record end without field end");

  // Every beat carries either a content byte or a field end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] || m_axis_tuser[1]))
    else $error("empty output beat");

  // A content byte never shares a beat with a field end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("content byte and field end in one beat");

  // Without a content byte the data lane reads zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("nonzero data without content byte");

  // A stalled beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
       && $stable(m_axis_tlast)))
    else $error("stalled output beat changed");

endmodule

bind csv_byte_tokenizer_top cbt_checker u_cbt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
